// ----- rtl/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg: shared types for the free list slot allocator
// Operation codes, fixed field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package fsa_pkg;

  // fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned GRANT_W = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CFG_W   = 9;

  // saturation value of the freed count
  localparam logic [COUNT_W-1:0] FREED_MAX = '1;

  // register reset value of slots_in_use
  localparam int unsigned CFG_RESET = 256;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_MARK      = 2'd2,
    OP_RESET_ALL = 2'd3
  } op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic sweep_init;
    logic sweep_step;
    logic alloc_read;
    logic alloc_pop;
    logic free_push;
    logic walk_init;
    logic walk_read;
    logic walk_step;
    logic emit;
    logic emit_oom;
    logic emit_freed;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic head_empty;
    logic slot_ok;
    logic walk_done;
    logic sweep_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/fsa_ram.sv -----
// ----------------------------------------------------------------------------
// fsa_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/fsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsa_ctrl: allocator controller
// Sequences alloc, free, walk and rechain sweep over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [fsa_pkg::OP_W-1:0]       op,
  input  wire fsa_pkg::dp_status_t            status,
  output logic                                busy,
  output fsa_pkg::ctrl_cmd_t                  cmd
);

  typedef enum logic [4:0] {
    S_SWEEP   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_ALLOC_RD = 5'b00100,
    S_WALK_TEST = 5'b01000,
    S_WALK_RD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   from_op_r, from_op_nxt;

  // state and sweep origin flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SWEEP;
      from_op_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      from_op_r <= from_op_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    from_op_nxt = from_op_r;
    cmd         = '0;
    case (state_r)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          cmd.emit    = from_op_r;
          from_op_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (fsa_pkg::op_t'(op))
            fsa_pkg::OP_ALLOC: begin
              if (status.head_empty) begin
                cmd.emit     = 1'b1;
                cmd.emit_oom = 1'b1;
              end else begin
                cmd.alloc_read = 1'b1;
                state_nxt      = S_ALLOC_RD;
              end
            end
            fsa_pkg::OP_FREE: begin
              cmd.free_push = status.slot_ok;
              cmd.emit      = 1'b1;
            end
            fsa_pkg::OP_MARK: begin
              if (status.slot_ok && !status.head_empty) begin
                cmd.walk_init = 1'b1;
                state_nxt     = S_WALK_TEST;
              end else begin
                cmd.emit = 1'b1;
              end
            end
            fsa_pkg::OP_RESET_ALL: begin
              cmd.sweep_init = 1'b1;
              from_op_nxt    = 1'b1;
              state_nxt      = S_SWEEP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        cmd.alloc_pop = 1'b1;
        cmd.emit      = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK_TEST: begin
        if (status.walk_done) begin
          cmd.emit       = 1'b1;
          cmd.emit_freed = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.walk_read = 1'b1;
          state_nxt     = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_WALK_TEST;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/fsa_datapath.sv -----
// ----------------------------------------------------------------------------
// fsa_datapath: allocator datapath
// Link RAM, head pointer, walk and sweep registers, config and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_datapath #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fsa_pkg::ctrl_cmd_t               cmd,
  input  wire logic [fsa_pkg::SLOT_W-1:0]       slot,
  input  wire logic                             cfg_we,
  input  wire logic [fsa_pkg::CFG_W-1:0]        cfg_wdata,
  output fsa_pkg::dp_status_t                   status,
  output logic                                  res_valid,
  output logic      [fsa_pkg::GRANT_W-1:0]      res_granted,
  output logic      [fsa_pkg::COUNT_W-1:0]      res_freed,
  output logic                                  res_oom
);

  // link width holds the end marker, address width indexes the pool
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned AW = $clog2(POOL_SLOTS);
  localparam logic [31:0] P32 = 32'(POOL_SLOTS);
  localparam logic [CW-1:0] END_MARK = CW'(POOL_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_SLOTS - 1);
  localparam int unsigned N_RESET =
    (POOL_SLOTS < fsa_pkg::CFG_RESET) ? POOL_SLOTS : fsa_pkg::CFG_RESET;

  logic [fsa_pkg::CFG_W-1:0]   cfg_r;
  logic [CW-1:0]               n_r, n_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               cur_r, cur_nxt;
  logic [CW-1:0]               stop_r, stop_nxt;
  logic [CW-1:0]               steps_r, steps_nxt;
  logic [fsa_pkg::COUNT_W-1:0] freed_r, freed_nxt;

  logic                        valid_r;
  logic [fsa_pkg::GRANT_W-1:0] granted_r;
  logic [fsa_pkg::COUNT_W-1:0] freed_out_r;
  logic                        oom_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;
  logic [CW-1:0] idx_plus1;
  logic [CW-1:0] cfg_clamped;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= fsa_pkg::CFG_W'(fsa_pkg::CFG_RESET);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // clamp slots_in_use to 1..POOL_SLOTS
  always_comb begin
    if (cfg_r == '0) begin
      cfg_clamped = CW'(1);
    end else if (32'(cfg_r) > P32) begin
      cfg_clamped = END_MARK;
    end else begin
      cfg_clamped = CW'(cfg_r);
    end
  end

  // rechain sweep link value
  assign idx_plus1 = CW'(idx_r) + CW'(1);

  // link memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = (idx_plus1 < n_r) ? idx_plus1 : END_MARK;
    if (cmd.free_push) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(slot);
      ram_wdata = head_r;
    end else if (cmd.walk_step) begin
      ram_we    = 1'b1;
      ram_waddr = cur_r[AW-1:0];
      ram_wdata = head_r;
    end else if (cmd.sweep_step) begin
      ram_we    = 1'b1;
    end
    ram_raddr = cmd.walk_read ? cur_r[AW-1:0] : head_r[AW-1:0];
  end

  fsa_ram #(
    .WIDTH (CW),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pointer, walk and sweep register updates
  always_comb begin
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    head_nxt  = head_r;
    cur_nxt   = cur_r;
    stop_nxt  = stop_r;
    steps_nxt = steps_r;
    freed_nxt = freed_r;
    if (cmd.sweep_init) begin
      idx_nxt = '0;
      n_nxt   = cfg_clamped;
    end
    if (cmd.sweep_step) begin
      idx_nxt = idx_r + AW'(1);
      if (idx_r == LAST_IDX) begin
        head_nxt = '0;
      end
    end
    if (cmd.alloc_pop) begin
      head_nxt = ram_rdata;
    end
    if (cmd.free_push) begin
      head_nxt = CW'(slot);
    end
    if (cmd.walk_init) begin
      stop_nxt  = head_r;
      cur_nxt   = CW'(slot);
      steps_nxt = '0;
      freed_nxt = '0;
    end
    if (cmd.walk_step) begin
      head_nxt  = cur_r;
      cur_nxt   = ram_rdata;
      steps_nxt = steps_r + CW'(1);
      if (freed_r != fsa_pkg::FREED_MAX) begin
        freed_nxt = freed_r + fsa_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= CW'(N_RESET);
      idx_r  <= '0;
      head_r <= '0;
    end else begin
      n_r    <= n_nxt;
      idx_r  <= idx_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    stop_r  <= stop_nxt;
    steps_r <= steps_nxt;
    freed_r <= freed_nxt;
  end

  // status to controller
  assign status.head_empty = (32'(head_r) >= P32);
  assign status.slot_ok    = (32'(slot) < P32);
  assign status.walk_done  = (cur_r == stop_r) || (32'(cur_r) >= P32) ||
                             (steps_r == END_MARK);
  assign status.sweep_last = (idx_r == LAST_IDX);

  // result registers, strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    granted_r   <= cmd.alloc_pop ? fsa_pkg::GRANT_W'(head_r) : '0;
    freed_out_r <= cmd.emit_freed ? freed_r : '0;
    oom_r       <= cmd.emit_oom;
  end

  assign res_valid   = valid_r;
  assign res_granted = granted_r;
  assign res_freed   = freed_out_r;
  assign res_oom     = oom_r;

endmodule

`default_nettype wire

// ----- rtl/free_list_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// free_list_slot_allocator_top: free list slot allocator
// Fixed pool of slots kept as a singly linked free list in a link RAM.
//
//   channel   ports                                              handshake
//   input     in_op, in_slot                                     start & !busy
//   result    out_granted_slot, out_freed_count,                 out_valid strobe
//             out_out_of_memory
//   config    cfg_wdata                                          cfg_we
//
// Alloc issues one link RAM read and pops the head in S_ALLOC_RD; free and an empty alloc finish in S_IDLE.
// Reset from mark passes S_WALK_TEST and S_WALK_RD once per freed slot; a null mark or empty list ends in S_IDLE.
// Reset all runs a rechain sweep with one RAM write a cycle.
// After reset the same sweep runs with busy high.
// Each result shows on out_valid for one cycle, the cycle after the work ends;
// the receiver cannot stall, config writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_slot_allocator_top #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [fsa_pkg::OP_W-1:0]       in_op,
  input  wire logic [fsa_pkg::SLOT_W-1:0]     in_slot,
  output logic                                out_valid,
  output logic      [fsa_pkg::GRANT_W-1:0]    out_granted_slot,
  output logic      [fsa_pkg::COUNT_W-1:0]    out_freed_count,
  output logic                                out_out_of_memory,
  input  wire logic                           cfg_we,
  input  wire logic [fsa_pkg::CFG_W-1:0]      cfg_wdata
);

  fsa_pkg::ctrl_cmd_t  cmd;
  fsa_pkg::dp_status_t status;

  // controller
  fsa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_op),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath
  fsa_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .slot        (in_slot),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .status      (status),
    .res_valid   (out_valid),
    .res_granted (out_granted_slot),
    .res_freed   (out_freed_count),
    .res_oom     (out_out_of_memory)
  );

`ifndef NO_ASSERTIONS
  // a result only follows an accepted transaction or ongoing work
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a transaction in flight");

  // out of memory carries no grant and no count
  a_oom_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_out_of_memory |-> (out_valid && out_granted_slot == '0 &&
                           out_freed_count == '0))
    else $error("out of memory result with stray payload");

  // at most one link RAM writer per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sweep_step, cmd.free_push, cmd.walk_step}))
    else $error("link RAM write conflict");

  // reset all always enters the sweep
  a_reset_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == fsa_pkg::OP_RESET_ALL) |=> busy)
    else $error("reset all did not start the sweep");
`endif

endmodule

`default_nettype wire
